>>> hw/rtl/fact_pkg.sv
package fact_pkg;

    // Result codes
    typedef enum logic [2:0] {
        OC_FWD  = 3'd0,
        OC_REV  = 3'd1,
        OC_NEW  = 3'd2,
        OC_FULL = 3'd3,
        OC_UNK  = 3'd4
    } t_outcome;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } t_ctl_state;

    // Register index, taken from paddr[2]
    localparam logic [0:0] REG_STATE_BITS = 1'b0;
    localparam logic [4:0] STATE_BITS_RST = 5'd16;

    localparam int FIELD_W = 16;   // input state field width
    localparam int IDX_W   = 6;    // entry_index width
    localparam int CNT_W   = 8;    // hit and state totals
    localparam int USED_W  = 7;    // entries_used width

    typedef struct packed {
        logic [FIELD_W-1:0] from_state;
        logic [FIELD_W-1:0] to_state;
        logic               hit_flag;
        logic               unknown_flag;
    } t_in_word;

    typedef struct packed {
        logic [2:0]        outcome;
        logic [IDX_W-1:0]  entry_index;
        logic [CNT_W-1:0]  transitions_hit;
        logic [CNT_W-1:0]  distinct_states;
        logic [USED_W-1:0] entries_used;
    } t_out_word;

    // Per-cell command from the controller
    typedef struct packed {
        logic wr_new;
        logic set_fwd;
        logic set_rev;
    } t_cell_cmd;

    // Per-cell status toward the controller
    typedef struct packed {
        logic fwd_m;
        logic rev_m;
        logic f_known;
        logic t_known;
        logic fwd_hit;
        logic rev_hit;
    } t_cell_stat;

endpackage

>>> hw/rtl/fact_cell.sv
module fact_cell
    import fact_pkg::*;
#(
    parameter int KW = 16
) (
    input  logic          i_clk,
    input  logic [KW-1:0] i_key_from,
    input  logic [KW-1:0] i_key_to,
    input  logic [KW-1:0] i_mask,
    input  logic          i_hit,
    input  logic          i_occ,
    input  t_cell_cmd     i_cmd,
    output t_cell_stat    o_stat
);

    logic [KW-1:0] r_from;
    logic [KW-1:0] r_to;
    logic          r_fwd;
    logic          r_rev;
    logic [KW-1:0] w_mf;
    logic [KW-1:0] w_mt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_new) begin
            r_from <= i_key_from;
            r_to   <= i_key_to;
            r_fwd  <= i_hit;
            r_rev  <= 1'b0;
        end else begin
            if (i_cmd.set_fwd && i_hit) begin
                r_fwd <= 1'b1;
            end
            if (i_cmd.set_rev && i_hit) begin
                r_rev <= 1'b1;
            end
        end
    end

    // stored values are compared under the current mask
    assign w_mf = r_from & i_mask;
    assign w_mt = r_to & i_mask;

    always_comb begin
        o_stat.fwd_m   = i_occ && (w_mf == i_key_from) && (w_mt == i_key_to);
        o_stat.rev_m   = i_occ && (w_mf == i_key_to) && (w_mt == i_key_from);
        o_stat.f_known = i_occ && ((w_mf == i_key_from) || (w_mt == i_key_from));
        o_stat.t_known = i_occ && ((w_mf == i_key_to) || (w_mt == i_key_to));
        o_stat.fwd_hit = r_fwd;
        o_stat.rev_hit = r_rev;
    end

endmodule

>>> hw/rtl/fact_first.sv
module fact_first
    import fact_pkg::*;
#(
    parameter int N = 64
) (
    input  logic [N-1:0]         i_vec,
    output logic                 o_any,
    output logic [N-1:0]         o_onehot,
    output logic [$clog2(N)-1:0] o_idx
);

    localparam int IW = $clog2(N);

    // lowest set bit isolated by two's complement
    assign o_onehot = i_vec & (~i_vec + N'(1));
    assign o_any    = |i_vec;

    always_comb begin
        o_idx = '0;
        for (int i = 0; i < N; i++) begin
            if (o_onehot[i]) begin
                o_idx = o_idx | IW'(i);
            end
        end
    end

endmodule

>>> hw/rtl/fsm_arc_coverage_table_unit.sv
// Channel  Dir  Handshake                  Payload
// in       in   i_in_valid / o_in_ready    i_in_word  (t_in_word)
// out      out  o_out_valid / i_out_ready  o_out_word (t_out_word)
// cfg      in   APB psel/penable/pready    pwdata[4:0] -> state_bits
//
// For each word the key is registered at accept, all entry cells compare it
// in parallel into registered match flags in ST_CMP, and ST_UPD then picks
// the lowest matching entry and updates the table and counts.
// A new word is taken in the update cycle as the result is loaded.
// The output register holds one result; while it is full the update waits.
// Synchronous active-low reset clears control and counts, not the entries.
module fsm_arc_coverage_table_unit
    import fact_pkg::*;
#(
    parameter int STATE_WIDTH = 16,
    parameter int TABLE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int KW = (STATE_WIDTH < FIELD_W) ? STATE_WIDTH : FIELD_W;
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_ctl_state r_state, n_state;

    logic [4:0]       r_state_bits;
    logic [KW-1:0]    r_from;
    logic [KW-1:0]    r_to;
    logic             r_hit;
    logic             r_unk;
    logic [CW-1:0]    r_count, n_count;
    logic [CNT_W-1:0] r_hit_total, n_hit_total;
    logic [CNT_W-1:0] r_state_total, n_state_total;
    logic             r_out_valid;
    t_out_word        r_out, n_out;

    logic [TABLE_DEPTH-1:0] r_fwd_v, r_rev_v, r_fk_v, r_tk_v;
    logic [TABLE_DEPTH-1:0] w_fwd_v, w_rev_v, w_fk_v, w_tk_v;
    logic [TABLE_DEPTH-1:0] w_fhit_v, w_rhit_v, w_occ, w_new_sel;
    logic [TABLE_DEPTH-1:0] w_fwd_oh, w_rev_oh;
    logic                   w_fwd_any, w_rev_any;
    logic [IW-1:0]          w_fwd_idx, w_rev_idx;

    t_cell_stat w_stat [TABLE_DEPTH];
    t_cell_cmd  w_cmd  [TABLE_DEPTH];

    logic [4:0]    w_eff;
    logic [KW-1:0] w_mask;
    logic          w_accept;
    logic          w_load;
    logic          w_cfg_wr;
    t_outcome      w_outcome;
    logic [IW-1:0] w_idx;
    logic          w_do_fwd, w_do_rev, w_do_new;
    logic [31:0]   w_idx32;
    logic [31:0]   w_cnt32;

    // ---------------- configuration ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2:2] == REG_STATE_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state_bits <= STATE_BITS_RST;
        end else if (w_cfg_wr) begin
            r_state_bits <= pwdata[4:0];
        end
    end

    assign prdata = (paddr[2:2] == REG_STATE_BITS) ? {27'd0, r_state_bits} : 32'd0;

    // zero acts as one, anything above the stored width is clamped
    always_comb begin
        if (r_state_bits == 5'd0) begin
            w_eff = 5'd1;
        end else if (r_state_bits > 5'(KW)) begin
            w_eff = 5'(KW);
        end else begin
            w_eff = r_state_bits;
        end
        w_mask = '0;
        for (int b = 0; b < KW; b++) begin
            if (b < int'(w_eff)) begin
                w_mask[b] = 1'b1;
            end
        end
    end

    // ---------------- control ----------------
    assign w_load      = (r_state == ST_UPD) && (!r_out_valid || i_out_ready);
    assign o_in_ready  = (r_state == ST_IDLE) || w_load;
    assign w_accept    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_CMP;
            end
            ST_CMP: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                if (w_load) n_state = w_accept ? ST_CMP : ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_from <= i_in_word.from_state[KW-1:0] & w_mask;
            r_to   <= i_in_word.to_state[KW-1:0] & w_mask;
            r_hit  <= i_in_word.hit_flag;
            r_unk  <= i_in_word.unknown_flag;
        end
        if (r_state == ST_CMP) begin
            r_fwd_v <= w_fwd_v;
            r_rev_v <= w_rev_v;
            r_fk_v  <= w_fk_v;
            r_tk_v  <= w_tk_v;
        end
    end

    // ---------------- entry cells ----------------
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        fact_cell #(
            .KW(KW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_key_from (r_from),
            .i_key_to   (r_to),
            .i_mask     (w_mask),
            .i_hit      (r_hit),
            .i_occ      (w_occ[g]),
            .i_cmd      (w_cmd[g]),
            .o_stat     (w_stat[g])
        );
    end

    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_occ[i]     = CW'(i) < r_count;
            w_new_sel[i] = IW'(i) == r_count[IW-1:0];
            w_fwd_v[i]   = w_stat[i].fwd_m;
            w_rev_v[i]   = w_stat[i].rev_m;
            w_fk_v[i]    = w_stat[i].f_known;
            w_tk_v[i]    = w_stat[i].t_known;
            w_fhit_v[i]  = w_stat[i].fwd_hit;
            w_rhit_v[i]  = w_stat[i].rev_hit;
        end
    end

    fact_first #(
        .N(TABLE_DEPTH)
    ) u_first_fwd (
        .i_vec    (r_fwd_v),
        .o_any    (w_fwd_any),
        .o_onehot (w_fwd_oh),
        .o_idx    (w_fwd_idx)
    );

    fact_first #(
        .N(TABLE_DEPTH)
    ) u_first_rev (
        .i_vec    (r_rev_v),
        .o_any    (w_rev_any),
        .o_onehot (w_rev_oh),
        .o_idx    (w_rev_idx)
    );

    // ---------------- update ----------------
    always_comb begin
        w_do_fwd      = 1'b0;
        w_do_rev      = 1'b0;
        w_do_new      = 1'b0;
        w_idx         = '0;
        n_count       = r_count;
        n_hit_total   = r_hit_total;
        n_state_total = r_state_total;
        if (r_unk) begin
            w_outcome = OC_UNK;
        end else if (w_fwd_any) begin
            w_outcome = OC_FWD;
            w_idx     = w_fwd_idx;
            w_do_fwd  = 1'b1;
            if (r_hit && !(|(w_fwd_oh & w_fhit_v))) begin
                n_hit_total = r_hit_total + CNT_W'(1);
            end
        end else if (w_rev_any) begin
            w_outcome = OC_REV;
            w_idx     = w_rev_idx;
            w_do_rev  = 1'b1;
            if (r_hit && !(|(w_rev_oh & w_rhit_v))) begin
                n_hit_total = r_hit_total + CNT_W'(1);
            end
        end else if (r_count == CW'(TABLE_DEPTH)) begin
            w_outcome = OC_FULL;
        end else begin
            w_outcome     = OC_NEW;
            w_idx         = r_count[IW-1:0];
            w_do_new      = 1'b1;
            n_count       = r_count + CW'(1);
            n_hit_total   = r_hit_total + CNT_W'(r_hit);
            n_state_total = r_state_total + CNT_W'(!(|r_fk_v))
                          + CNT_W'((r_to != r_from) && !(|r_tk_v));
        end
    end

    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_cmd[i].wr_new  = w_load && w_do_new && w_new_sel[i];
            w_cmd[i].set_fwd = w_load && w_do_fwd && w_fwd_oh[i];
            w_cmd[i].set_rev = w_load && w_do_rev && w_rev_oh[i];
        end
    end

    assign w_idx32 = 32'(w_idx);
    assign w_cnt32 = 32'(n_count);

    always_comb begin
        n_out.outcome         = w_outcome;
        n_out.entry_index     = w_idx32[IDX_W-1:0];
        n_out.transitions_hit = n_hit_total;
        n_out.distinct_states = n_state_total;
        n_out.entries_used    = w_cnt32[USED_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_hit_total   <= '0;
            r_state_total <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_load) begin
                r_count       <= n_count;
                r_hit_total   <= n_hit_total;
                r_state_total <= n_state_total;
                r_out_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // ---------------- checks ----------------
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // match flags are only meaningful once a compare has run
    a_fwd_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |-> $onehot0(w_fwd_oh))
        else $error("forward select not one-hot");

    a_accept_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_CMP))
        else $error("accepted word did not enter compare");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (w_outcome != OC_NEW)) |=> $stable(r_count))
        else $error("entry count moved without a new entry");

    a_load_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP) |=> !o_in_ready || (r_state == ST_UPD))
        else $error("compare not followed by update");

endmodule
